### hw/rtl/camera_format_to_rgb_converter_top_defines.svh
// Assertion macros used by the checker file.
`ifndef CAMERA_FORMAT_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define CAMERA_FORMAT_TO_RGB_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CFRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfrc assertion failed");

// Next-cycle implication, disabled while reset is low.
`define CFRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfrc assertion failed");

`endif

### hw/rtl/cfrc_pkg.sv
package cfrc_pkg;

    // Source pixel formats held in the pixel_format register
    typedef enum logic [2:0] {
        FMT_RGB8   = 3'd0,
        FMT_YUV444 = 3'd1,
        FMT_YUV422 = 3'd2,
        FMT_MONO8  = 3'd3,
        FMT_RGB16  = 3'd4
    } cfrc_fmt_t;

    // Register map
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FMT_W      = 3;

    // Work item passed from the front to the back through the queue.
    // For YUV work c0/c1/c2 are Y/U/V, otherwise they are R/G/B.
    typedef struct packed {
        logic       yuv;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       last;
    } cfrc_entry_t;

    // BT.601 coefficients, 16.16 fixed point
    localparam int COEF_W = 19;
    localparam logic signed [COEF_W-1:0] K_Y  = 19'sd76312;
    localparam logic signed [COEF_W-1:0] K_RV = 19'sd104597;
    localparam logic signed [COEF_W-1:0] K_GU = -19'sd25674;
    localparam logic signed [COEF_W-1:0] K_GV = -19'sd53279;
    localparam logic signed [COEF_W-1:0] K_BU = 19'sd132201;

    localparam logic [8:0] Y_OFFSET = 9'd16;
    localparam logic [8:0] C_OFFSET = 9'd128;

endpackage

### hw/rtl/cfrc_front.sv
module cfrc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfrc_pkg::cfrc_fmt_t  fmt,
    input  logic                 cfg_wr,
    input  logic                 raw_valid,
    output logic                 raw_ready,
    input  logic [15:0]          raw_word,
    input  logic                 frame_last,
    input  logic                 q_full,
    output logic                 q_push,
    output cfrc_pkg::cfrc_entry_t q_data
);
    import cfrc_pkg::*;

    logic [1:0] byte_phase_reg, byte_phase_next;
    logic [7:0] held_first_reg, held_first_next;
    logic [7:0] held_second_reg, held_second_next;
    logic       accept;
    logic       emit;
    logic [7:0] b8;
    logic [7:0] bsel;

    assign raw_ready = !q_full;
    assign accept    = raw_valid && raw_ready;
    assign b8        = raw_word[7:0];
    assign bsel      = (fmt == FMT_RGB16) ? raw_word[15:8] : raw_word[7:0];
    assign q_push    = accept && emit;

    // Classify the word against the byte phase and build the work item
    always_comb
    begin
        byte_phase_next  = byte_phase_reg;
        held_first_next  = held_first_reg;
        held_second_next = held_second_reg;
        emit             = 1'b0;
        q_data.yuv       = 1'b0;
        q_data.c0        = held_first_reg;
        q_data.c1        = held_second_reg;
        q_data.c2        = bsel;
        q_data.last      = frame_last;
        if (accept)
        begin
            case (fmt)
                FMT_RGB8, FMT_RGB16, FMT_YUV444:
                begin
                    case (byte_phase_reg)
                        2'd0:
                        begin
                            held_first_next = bsel;
                            byte_phase_next = 2'd1;
                        end
                        2'd1:
                        begin
                            held_second_next = bsel;
                            byte_phase_next  = 2'd2;
                        end
                        default:
                        begin
                            // Complete the triple; u,y,v order for YUV
                            emit            = 1'b1;
                            byte_phase_next = 2'd0;
                            if (fmt == FMT_YUV444)
                            begin
                                q_data.yuv = 1'b1;
                                q_data.c0  = held_second_reg;
                                q_data.c1  = held_first_reg;
                            end
                        end
                    endcase
                end
                FMT_YUV422:
                begin
                    case (byte_phase_reg)
                        2'd0:
                        begin
                            held_first_next = b8;
                            byte_phase_next = 2'd1;
                        end
                        2'd1:
                        begin
                            held_second_next = b8;
                            byte_phase_next  = 2'd2;
                        end
                        2'd2:
                        begin
                            // First pixel: y0 with u and this v; keep v for y1
                            emit             = 1'b1;
                            q_data.yuv       = 1'b1;
                            q_data.c0        = held_second_reg;
                            q_data.c1        = held_first_reg;
                            q_data.c2        = b8;
                            held_second_next = b8;
                            byte_phase_next  = 2'd3;
                        end
                        default:
                        begin
                            // Second pixel: y1 with shared u and v
                            emit            = 1'b1;
                            q_data.yuv      = 1'b1;
                            q_data.c0       = b8;
                            q_data.c1       = held_first_reg;
                            q_data.c2       = held_second_reg;
                            byte_phase_next = 2'd0;
                        end
                    endcase
                end
                FMT_MONO8:
                begin
                    emit            = 1'b1;
                    q_data.c0       = b8;
                    q_data.c1       = b8;
                    q_data.c2       = b8;
                    byte_phase_next = 2'd0;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
            if (frame_last)
            begin
                byte_phase_next = 2'd0;
            end
        end
        if (cfg_wr)
        begin
            byte_phase_next = 2'd0;
        end
    end

    // Hold phase and group bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_phase_reg  <= 2'd0;
            held_first_reg  <= 8'd0;
            held_second_reg <= 8'd0;
        end
        else
        begin
            byte_phase_reg  <= byte_phase_next;
            held_first_reg  <= held_first_next;
            held_second_reg <= held_second_next;
        end
    end

endmodule

### hw/rtl/cfrc_queue.sv
module cfrc_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cfrc_pkg::cfrc_entry_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  valid,
    output cfrc_pkg::cfrc_entry_t pop_data
);
    import cfrc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cfrc_entry_t      slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign valid    = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    // Advance pointers with wrap and track the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/cfrc_back.sv
module cfrc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  cfrc_pkg::cfrc_entry_t q_data,
    output logic                  q_pop,
    output logic                  pix_valid,
    input  logic                  pix_ready,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic                  last_pixel
);
    import cfrc_pkg::*;

    localparam int IN_W   = 9;
    localparam int PROD_W = COEF_W + IN_W;
    localparam int SUM_W  = PROD_W + 2;

    // Stage 1: products
    logic                     s1_valid_reg, s1_valid_next;
    cfrc_entry_t              s1_item_reg;
    logic signed [PROD_W-1:0] p_y_reg, p_rv_reg, p_gu_reg, p_gv_reg, p_bu_reg;
    logic signed [PROD_W-1:0] p_y_next, p_rv_next, p_gu_next, p_gv_next, p_bu_next;
    logic signed [IN_W-1:0]   y_s, u_s, v_s;

    // Stage 2: output register
    logic                     out_valid_reg, out_valid_next;
    logic [7:0]               red_reg, green_reg, blue_reg;
    logic [7:0]               red_next, green_next, blue_next;
    logic                     last_reg;
    logic signed [SUM_W-1:0]  sum_r, sum_g, sum_b;

    logic out_free;
    logic s1_take;

    function automatic logic [7:0] clamp_shift(input logic signed [SUM_W-1:0] s);
        logic [7:0] res;
        if (s[SUM_W-1])
        begin
            res = 8'd0;
        end
        else if (|s[SUM_W-2:24])
        begin
            res = 8'hFF;
        end
        else
        begin
            res = s[23:16];
        end
        return res;
    endfunction

    assign out_free = !out_valid_reg || pix_ready;
    assign s1_take  = !s1_valid_reg || out_free;
    assign q_pop    = q_valid && s1_take;

    // Remove offsets and form the coefficient products
    always_comb
    begin
        y_s       = signed'({1'b0, q_data.c0} - Y_OFFSET);
        u_s       = signed'({1'b0, q_data.c1} - C_OFFSET);
        v_s       = signed'({1'b0, q_data.c2} - C_OFFSET);
        p_y_next  = PROD_W'(K_Y)  * PROD_W'(y_s);
        p_rv_next = PROD_W'(K_RV) * PROD_W'(v_s);
        p_gu_next = PROD_W'(K_GU) * PROD_W'(u_s);
        p_gv_next = PROD_W'(K_GV) * PROD_W'(v_s);
        p_bu_next = PROD_W'(K_BU) * PROD_W'(u_s);
        s1_valid_next = s1_take ? q_valid : s1_valid_reg;
    end

    // Sum, floor-shift and clamp, or pass bytes through
    always_comb
    begin
        sum_r = SUM_W'(p_y_reg) + SUM_W'(p_rv_reg);
        sum_g = SUM_W'(p_y_reg) + SUM_W'(p_gu_reg) + SUM_W'(p_gv_reg);
        sum_b = SUM_W'(p_y_reg) + SUM_W'(p_bu_reg);
        if (s1_item_reg.yuv)
        begin
            red_next   = clamp_shift(sum_r);
            green_next = clamp_shift(sum_g);
            blue_next  = clamp_shift(sum_b);
        end
        else
        begin
            red_next   = s1_item_reg.c0;
            green_next = s1_item_reg.c1;
            blue_next  = s1_item_reg.c2;
        end
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load stage 1 on pop
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_item_reg <= q_data;
            p_y_reg     <= p_y_next;
            p_rv_reg    <= p_rv_next;
            p_gu_reg    <= p_gu_next;
            p_gv_reg    <= p_gv_next;
            p_bu_reg    <= p_bu_next;
        end
    end

    // Load the output register when it is free
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            last_reg  <= s1_item_reg.last;
        end
    end

    assign pix_valid  = out_valid_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign last_pixel = last_reg;

endmodule

### hw/rtl/camera_format_to_rgb_converter_top.sv
// Channel   Handshake              Payload
// raw       raw_valid/raw_ready    raw_word[15:0], frame_last
// pix       pix_valid/pix_ready    red[7:0], green[7:0], blue[7:0], last_pixel
// cfg       psel/penable/pready    paddr, pwrite, pwdata, prdata (pixel_format)
//
// One raw word per cycle is taken while the work queue has room; a word that
// completes a pixel is written into the queue, popped into the stage-1 product
// registers and then loaded into the output register, from which it transfers.
// Sustained rate is one word per clock while pix_ready holds high; the queue
// feeds the two-stage multiply/clamp path. rst_n clears phase, queue, pipeline
// valids and format. A stalled pixel holds in the output register; the queue
// absorbs words until it fills, then raw_ready drops.
module camera_format_to_rgb_converter_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cfrc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cfrc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cfrc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            raw_valid,
    output logic                            raw_ready,
    input  logic [15:0]                     raw_word,
    input  logic                            frame_last,
    output logic                            pix_valid,
    input  logic                            pix_ready,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic                            last_pixel
);
    import cfrc_pkg::*;

    cfrc_fmt_t   fmt_reg, fmt_next;
    logic        cfg_wr;
    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    cfrc_entry_t q_in;
    cfrc_entry_t q_out;

    // Register write: pixel_format answers at every address with paddr[2] low
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign fmt_next = cfg_wr ? cfrc_fmt_t'(pwdata[FMT_W-1:0]) : fmt_reg;
    assign prdata = paddr[2] ? '0 : CFG_DATA_W'(fmt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_RGB8;
        end
        else
        begin
            fmt_reg <= fmt_next;
        end
    end

    cfrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .fmt        (fmt_reg),
        .cfg_wr     (cfg_wr),
        .raw_valid  (raw_valid),
        .raw_ready  (raw_ready),
        .raw_word   (raw_word),
        .frame_last (frame_last),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    cfrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    cfrc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .last_pixel (last_pixel)
    );

endmodule

### hw/rtl/cfrc_checker.sv
`include "camera_format_to_rgb_converter_top_defines.svh"

module cfrc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [cfrc_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [cfrc_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [cfrc_pkg::CFG_DATA_W-1:0] prdata,
    input logic                            pready,
    input logic                            pix_valid,
    input logic                            pix_ready,
    input logic [7:0]                      red,
    input logic [7:0]                      green,
    input logic [7:0]                      blue,
    input logic                            last_pixel
);
    import cfrc_pkg::*;

    // A stalled pixel transfer keeps its valid and payload
    `CFRC_ASSERT_NEXT(a_pix_hold, clk, rst_n, pix_valid && !pix_ready, pix_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(last_pixel))

    // The register port never waits
    `CFRC_ASSERT_NOW(a_pready_high, clk, rst_n, 1'b1, pready)

    // Only the format bits are ever read back
    `CFRC_ASSERT_NOW(a_prdata_narrow, clk, rst_n, 1'b1, prdata[CFG_DATA_W-1:FMT_W] == '0)

    // A format write reads back on the following cycle
    `CFRC_ASSERT_NEXT(a_fmt_readback, clk, rst_n, psel && penable && pwrite && pready && !paddr[2], paddr[2] || (prdata[FMT_W-1:0] == $past(pwdata[FMT_W-1:0])))

endmodule

bind camera_format_to_rgb_converter_top cfrc_checker u_cfrc_checker (.*);

### tb/camera_format_to_rgb_converter_top_tb.sv
module camera_format_to_rgb_converter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfrc_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SEG_ITEMS      = 75;
    localparam int SEG_ITEMS_NONE = 10;

    // BT.601 16.16 coefficients and offsets
    localparam int COEF_Y  = 76312;
    localparam int COEF_RV = 104597;
    localparam int COEF_GU = -25674;
    localparam int COEF_GV = -53279;
    localparam int COEF_BU = 132201;
    localparam int LUMA_OFS   = 16;
    localparam int CHROMA_OFS = 128;

    // Register map and formats outside the enum
    localparam logic [CFG_ADDR_W-1:0] FMT_ADDR = '0;
    localparam logic [2:0] FMT_NONE_5 = 3'd5;
    localparam logic [2:0] FMT_NONE_7 = 3'd7;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       lp;
    } pix_t;

    typedef struct packed {
        logic [2:0]  fmt;
        logic        wr;
        logic [15:0] word;
        logic        fl;
        logic        typed;
        pix_t        px;
    } row_t;

    localparam int DIR_ROWS = 27;

    // Directed stimulus: typed pixels only where the answer is obvious
    row_t dir_tab [DIR_ROWS] = '{
        '{FMT_RGB8,   1'b0, 16'h00FF, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_RGB8,   1'b0, 16'h0000, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_RGB8,   1'b0, 16'hFF80, 1'b0, 1'b1, '{8'hFF, 8'h00, 8'h80, 1'b0}},
        // short group cut off by the end of frame
        '{FMT_RGB8,   1'b0, 16'h0011, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_RGB8,   1'b0, 16'h0022, 1'b1, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        // format write in mid group restarts the group
        '{FMT_RGB8,   1'b0, 16'h0033, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_RGB8,   1'b1, 16'h0044, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_RGB8,   1'b0, 16'h0055, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_RGB8,   1'b0, 16'h0066, 1'b1, 1'b1, '{8'h44, 8'h55, 8'h66, 1'b1}},
        '{FMT_RGB16,  1'b1, 16'hFF00, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_RGB16,  1'b0, 16'h00FF, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_RGB16,  1'b0, 16'h8001, 1'b1, 1'b1, '{8'hFF, 8'h00, 8'h80, 1'b1}},
        '{FMT_MONO8,  1'b1, 16'hAB00, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_MONO8,  1'b0, 16'h12FF, 1'b1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}},
        '{FMT_YUV444, 1'b1, 16'h0080, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_YUV444, 1'b0, 16'h0010, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_YUV444, 1'b0, 16'h0080, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_YUV444, 1'b0, 16'h0000, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_YUV444, 1'b0, 16'hFFFF, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_YUV444, 1'b0, 16'h00FF, 1'b1, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_YUV422, 1'b1, 16'h0080, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_YUV422, 1'b0, 16'h0010, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_YUV422, 1'b0, 16'h0080, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_YUV422, 1'b0, 16'h00EB, 1'b1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}},
        // unknown formats swallow words
        '{FMT_NONE_7, 1'b1, 16'hFFFF, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_NONE_7, 1'b0, 16'h1234, 1'b1, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{FMT_NONE_5, 1'b1, 16'h0000, 1'b1, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  raw_valid = 1'b0;
    logic                  raw_ready;
    logic [15:0]           raw_word = '0;
    logic                  frame_last = 1'b0;
    logic                  pix_valid;
    logic                  pix_ready = 1'b0;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic                  last_pixel;

    // Converter state mirror
    logic [2:0] fmt_q = FMT_RGB8;
    logic [1:0] grp_pos = '0;
    logic [7:0] hold_a = '0;
    logic [7:0] hold_b = '0;

    pix_t pending_pixels [$];
    logic drv_typed = 1'b0;
    pix_t drv_px = '0;
    int   err_count = 0;
    int   idle_cycles = 0;
    int   tx_idle_pct = 19;
    int   rx_idle_pct = 76;

    camera_format_to_rgb_converter_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .raw_valid  (raw_valid),
        .raw_ready  (raw_ready),
        .raw_word   (raw_word),
        .frame_last (frame_last),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .last_pixel (last_pixel)
    );

    always #CLK_HALF clk = ~clk;

    // Floor the 16.16 sum and saturate to a byte
    function automatic logic [7:0] clamp8(input int sum);
        int q;
        if (sum < 0)
            return 8'd0;
        q = sum >>> 16;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic pix_t yuv_to_rgb(input logic [7:0] yb, input logic [7:0] ub,
                                        input logic [7:0] vb);
        int   y;
        int   u;
        int   v;
        pix_t px;
        y = int'(yb) - LUMA_OFS;
        u = int'(ub) - CHROMA_OFS;
        v = int'(vb) - CHROMA_OFS;
        px.r  = clamp8(COEF_Y * y + COEF_RV * v);
        px.g  = clamp8(COEF_Y * y + COEF_GU * u + COEF_GV * v);
        px.b  = clamp8(COEF_Y * y + COEF_BU * u);
        px.lp = 1'b0;
        return px;
    endfunction

    // Advance the converter mirror by one word; returns 1 when a pixel comes out
    function automatic bit convert_word(input logic [15:0] w, input logic fl,
                                        output pix_t px);
        logic [7:0] b;
        bit         hit;
        hit = 1'b0;
        px  = '0;
        case (fmt_q)
            FMT_RGB8, FMT_RGB16, FMT_YUV444:
            begin
                b = (fmt_q == FMT_RGB16) ? w[15:8] : w[7:0];
                if (grp_pos == 2'd0)
                begin
                    hold_a  = b;
                    grp_pos = 2'd1;
                end
                else if (grp_pos == 2'd1)
                begin
                    hold_b  = b;
                    grp_pos = 2'd2;
                end
                else
                begin
                    if (fmt_q == FMT_YUV444)
                        px = yuv_to_rgb(hold_b, hold_a, b);
                    else
                        px = '{hold_a, hold_b, b, 1'b0};
                    hit     = 1'b1;
                    grp_pos = 2'd0;
                end
            end
            FMT_YUV422:
            begin
                b = w[7:0];
                if (grp_pos == 2'd0)
                begin
                    hold_a  = b;
                    grp_pos = 2'd1;
                end
                else if (grp_pos == 2'd1)
                begin
                    hold_b  = b;
                    grp_pos = 2'd2;
                end
                else if (grp_pos == 2'd2)
                begin
                    // first pixel of the pair; keep v for the second
                    px      = yuv_to_rgb(hold_b, hold_a, b);
                    hold_b  = b;
                    hit     = 1'b1;
                    grp_pos = 2'd3;
                end
                else
                begin
                    px      = yuv_to_rgb(b, hold_a, hold_b);
                    hit     = 1'b1;
                    grp_pos = 2'd0;
                end
            end
            FMT_MONO8:
            begin
                px      = '{w[7:0], w[7:0], w[7:0], 1'b0};
                hit     = 1'b1;
                grp_pos = 2'd0;
            end
            default:
                hit = 1'b0;
        endcase
        px.lp = fl;
        if (fl)
            grp_pos = 2'd0;
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Receiver backpressure
    always @(negedge clk)
        pix_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // Capture accepted words, check pixels, watch for a hang
    always @(posedge clk)
    begin
        pix_t px;
        pix_t want;
        bit   hit;
        if (rst_n)
        begin
            if (pix_valid && pix_ready)
            begin
                if (pending_pixels.size() == 0)
                    report_mismatch("unexpected pixel",
                                    32'({red, green, blue, last_pixel}), 0);
                else
                begin
                    want = pending_pixels.pop_front();
                    if (red !== want.r)
                        report_mismatch("red", 32'(red), 32'(want.r));
                    if (green !== want.g)
                        report_mismatch("green", 32'(green), 32'(want.g));
                    if (blue !== want.b)
                        report_mismatch("blue", 32'(blue), 32'(want.b));
                    if (last_pixel !== want.lp)
                        report_mismatch("last_pixel", 32'(last_pixel), 32'(want.lp));
                end
            end
            if (raw_valid && raw_ready)
            begin
                hit = convert_word(raw_word, frame_last, px);
                if (drv_typed)
                    px = drv_px;
                if (hit || drv_typed)
                    pending_pixels.push_back(px);
            end
            if ((pix_valid && pix_ready) || (raw_valid && raw_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TIMEOUT at %0t with %0d pixels outstanding", $realtime,
                         pending_pixels.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Offer one word and hold it until the transfer
    task automatic send_word(input logic [15:0] w, input logic fl, input logic typed,
                             input pix_t px);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            raw_valid <= 1'b0;
            @(negedge clk);
        end
        raw_valid  <= 1'b1;
        raw_word   <= w;
        frame_last <= fl;
        drv_typed  <= typed;
        drv_px     <= px;
        do
            @(posedge clk);
        while (!(raw_valid && raw_ready));
        @(negedge clk);
    endtask

    // Drop valid and let the pipeline drain
    task automatic wait_idle();
        raw_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write pixel_format, then read it back
    task automatic cfg_write(input logic [2:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FMT_ADDR;
        pwdata  <= CFG_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        fmt_q   = value;
        grp_pos = 2'd0;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[FMT_W-1:0] !== value)
            report_mismatch("pixel_format readback", prdata, 32'(value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 19))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h00FF;
            3: return 16'hFF00;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [2:0] seg_fmt;
        int         grp;
        int         n_items;
        int         frame_left;
        logic       fl;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_tab[i].wr)
            begin
                wait_idle();
                cfg_write(dir_tab[i].fmt);
            end
            send_word(dir_tab[i].word, dir_tab[i].fl, dir_tab[i].typed, dir_tab[i].px);
        end

        // Random frames under three idle mixes
        for (int m = 0; m < 3; m++)
        begin
            tx_idle_pct = (m == 0) ? 19 : (m == 1) ? 76 : 0;
            rx_idle_pct = (m == 0) ? 76 : (m == 1) ? 19 : 0;
            for (int s = 0; s < 8; s++)
            begin
                seg_fmt = 3'((s + 3 * m) % 8);
                wait_idle();
                cfg_write(seg_fmt);
                grp = (seg_fmt == FMT_YUV422) ? 4 : (seg_fmt == FMT_MONO8) ? 1 : 3;
                n_items = (seg_fmt > FMT_RGB16) ? SEG_ITEMS_NONE : SEG_ITEMS;
                frame_left = 0;
                for (int i = 0; i < n_items; i++)
                begin
                    // hold off once until every pixel has come back
                    if (m == 0 && s == 2 && i == n_items / 2)
                    begin
                        raw_valid <= 1'b0;
                        do
                            @(negedge clk);
                        while (pending_pixels.size() != 0);
                    end
                    if (frame_left == 0)
                    begin
                        frame_left = grp * $urandom_range(1, 8);
                        if ($urandom_range(0, 99) < 15)
                            frame_left = $urandom_range(1, 12);
                    end
                    fl = (frame_left == 1);
                    frame_left--;
                    send_word(pick_word(), fl, 1'b0, '0);
                end
            end
        end

        wait_idle();
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
